/* hw/rtl/swm_pkg.sv */
// Package for the sliding window maximum block.
// Sizes, controller/datapath command and status types, state codes, pointer helpers.
// No dependencies; used by the top module, the controller and the datapath.
package swm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int LEN_W        = 7;                        // window_len register width
  localparam int PTR_W        = $clog2(WINDOW_MAX);       // deque slot index
  localparam int CNT_W        = $clog2(WINDOW_MAX + 1);   // occupancy, seen count
  localparam int POS_MOD      = 2 * WINDOW_MAX;           // stream position modulus
  localparam int POS_W        = $clog2(POS_MOD);
  localparam int ENTRY_W      = POS_W + SAMPLE_WIDTH;     // {position, value}

  // controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_RD_HEAD  = 6'b000010,
    S_CHK_HEAD = 6'b000100,
    S_RD_BACK  = 6'b001000,
    S_CHK_BACK = 6'b010000,
    S_APPEND   = 6'b100000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic rd_back;     // read address: back entry (else front entry)
    logic evict;       // drop the front entry
    logic save_front;  // front entry survives: keep its value
    logic pop;         // drop the back entry
    logic commit;      // append, update counters, emit result if due
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic occ_zero;    // deque empty
    logic occ_one;     // one entry left
    logic aged;        // front entry read out is outside the window
    logic back_le;     // back entry read out is <= the new sample
    logic emit;        // this item yields a result
    logic out_free;    // output register can take a result
  } sts_t;

  // (ptr + cnt) mod WINDOW_MAX, for ptr < WINDOW_MAX and cnt <= WINDOW_MAX
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(ptr) + (CNT_W+1)'(cnt);
    if (s >= (CNT_W+1)'(WINDOW_MAX)) begin
      s = s - (CNT_W+1)'(WINDOW_MAX);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

/* hw/rtl/sliding_window_maximum.sv */
// Sliding window maximum over a signed sample stream, monotonic deque in a 64-entry RAM.
// One item at a time: an empty deque goes straight to the append step, else each entry examined
// takes a read step and a check step (front entries checked for age, back entries compared).
// The result is registered and shows in the cycle after the append step; a waiting result
// stalls only the append step of the next item. Synchronous active-low reset clears
// pointers, counters and output valid; window length resets to 1. No clearing pass.
module sliding_window_maximum (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                                    in_end_of_run,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  output logic                                    out_last,
  input  logic                                    cfg_we,
  input  logic [swm_pkg::LEN_W-1:0]               cfg_wdata
);

  swm_pkg::cmd_t cmd;
  swm_pkg::sts_t sts;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_sample),
    .in_end_of_run  (in_end_of_run),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_max (out_window_max),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef NO_ASSERTIONS
  // an accepted item takes the controller out of idle, so no second item is accepted straight after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a result is only committed when the output register has room
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && sts.emit |-> sts.out_free)
    else $error("result committed into a full output register");

  // never evict or pop from an empty deque
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict || cmd.pop |-> !sts.occ_zero)
    else $error("deque underflow");

  // a committed result lands in the output register
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && sts.emit |=> out_valid)
    else $error("committed result not shown");
`endif

endmodule

/* hw/rtl/swm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/swm_ctrl.sv */
// Controller for the sliding window maximum: sequences front eviction,
// back pops and the append/emit step. Depends on swm_pkg.
module swm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swm_pkg::sts_t sts,
  output swm_pkg::cmd_t cmd
);

  swm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == swm_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      swm_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.occ_zero ? swm_pkg::S_APPEND : swm_pkg::S_RD_HEAD;
        end
      end
      swm_pkg::S_RD_HEAD: begin
        state_nxt = swm_pkg::S_CHK_HEAD;
      end
      swm_pkg::S_CHK_HEAD: begin
        if (sts.aged) begin
          cmd.evict = 1'b1;
          state_nxt = sts.occ_one ? swm_pkg::S_APPEND : swm_pkg::S_RD_HEAD;
        end else begin
          cmd.save_front = 1'b1;
          state_nxt      = swm_pkg::S_RD_BACK;
        end
      end
      swm_pkg::S_RD_BACK: begin
        cmd.rd_back = 1'b1;
        state_nxt   = swm_pkg::S_CHK_BACK;
      end
      swm_pkg::S_CHK_BACK: begin
        if (sts.back_le) begin
          cmd.pop   = 1'b1;
          state_nxt = sts.occ_one ? swm_pkg::S_APPEND : swm_pkg::S_RD_BACK;
        end else begin
          state_nxt = swm_pkg::S_APPEND;
        end
      end
      swm_pkg::S_APPEND: begin
        // if this item yields a result, hold until the output register can take it
        if (!sts.emit || sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = swm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/swm_dp.sv */
// Datapath for the sliding window maximum: deque store, pointers, counters,
// window length register and output register. Depends on swm_pkg, swm_ram.
module swm_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                              in_end_of_run,
  input  logic                              cfg_we,
  input  logic [swm_pkg::LEN_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] out_window_max,
  output logic                              out_last,
  input  swm_pkg::cmd_t                     cmd,
  output swm_pkg::sts_t                     sts
);

  // item and control registers
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample_r;
  logic                                    end_r;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] front_r;
  logic [swm_pkg::PTR_W-1:0]               head_r, head_nxt;
  logic [swm_pkg::CNT_W-1:0]               occ_r, occ_nxt;
  logic [swm_pkg::POS_W-1:0]               pos_r, pos_nxt;
  logic [swm_pkg::CNT_W-1:0]               seen_r, seen_nxt, seen_inc;
  logic [swm_pkg::LEN_W-1:0]               wlen_r;
  logic                                    out_valid_r, out_valid_nxt;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] out_max_r;
  logic                                    out_last_r;

  logic [swm_pkg::CNT_W-1:0]               wlen_eff;
  logic [swm_pkg::PTR_W-1:0]               raddr, waddr;
  logic [swm_pkg::ENTRY_W-1:0]             rdata;
  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] rd_val;
  logic [swm_pkg::POS_W-1:0]               rd_pos;
  logic [swm_pkg::POS_W-1:0]               age;
  logic [swm_pkg::POS_W-1:0]               pos_inc;

  // deque store: {position, value}
  swm_ram #(
    .WIDTH (swm_pkg::ENTRY_W),
    .DEPTH (swm_pkg::WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (waddr),
    .wdata ({pos_r, sample_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_val = rdata[swm_pkg::SAMPLE_WIDTH-1:0];
  assign rd_pos = rdata[swm_pkg::ENTRY_W-1:swm_pkg::SAMPLE_WIDTH];

  // addresses: front, back (occupancy >= 1 there), append slot
  assign raddr = cmd.rd_back ? swm_pkg::ptr_add(head_r, occ_r - swm_pkg::CNT_W'(1)) : head_r;
  assign waddr = swm_pkg::ptr_add(head_r, occ_r);

  // effective window length: zero acts as one, saturates at the deque depth
  always_comb begin
    if (wlen_r == '0) begin
      wlen_eff = swm_pkg::CNT_W'(1);
    end else if (int'(wlen_r) > swm_pkg::WINDOW_MAX) begin
      wlen_eff = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
    end else begin
      wlen_eff = swm_pkg::CNT_W'(wlen_r);
    end
  end

  // age of the front entry, modulo the position range
  always_comb begin
    if (pos_r >= rd_pos) begin
      age = pos_r - rd_pos;
    end else begin
      age = swm_pkg::POS_W'(swm_pkg::POS_MOD - int'(rd_pos) + int'(pos_r));
    end
  end

  // position and seen count successors
  assign pos_inc  = (int'(pos_r) == swm_pkg::POS_MOD - 1) ? '0 : pos_r + swm_pkg::POS_W'(1);
  assign seen_inc = (int'(seen_r) == swm_pkg::WINDOW_MAX) ? seen_r
                                                          : seen_r + swm_pkg::CNT_W'(1);

  // status to controller
  always_comb begin
    sts.occ_zero = (occ_r == '0);
    sts.occ_one  = (occ_r == swm_pkg::CNT_W'(1));
    sts.aged     = (age >= swm_pkg::POS_W'(wlen_eff));
    sts.back_le  = (rd_val <= sample_r);
    sts.emit     = end_r || (seen_inc >= wlen_eff);
    sts.out_free = !out_valid_r || out_ready;
  end

  // pointer and counter updates
  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    priority if (cmd.evict) begin
      head_nxt = swm_pkg::ptr_add(head_r, swm_pkg::CNT_W'(1));
      occ_nxt  = occ_r - swm_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      occ_nxt  = occ_r - swm_pkg::CNT_W'(1);
    end else if (cmd.commit && end_r) begin
      head_nxt = '0;
      occ_nxt  = '0;
      pos_nxt  = '0;
      seen_nxt = '0;
    end else if (cmd.commit) begin
      occ_nxt  = occ_r + swm_pkg::CNT_W'(1);
      pos_nxt  = pos_inc;
      seen_nxt = seen_inc;
    end
  end

  // output register handshake
  always_comb begin
    if (cmd.commit && sts.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      pos_r       <= '0;
      seen_r      <= '0;
      wlen_r      <= swm_pkg::LEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      end_r    <= in_end_of_run;
    end
    if (cmd.save_front) begin
      front_r <= rd_val;
    end
    if (cmd.commit && sts.emit) begin
      // empty deque before append: the new sample is the front
      out_max_r  <= sts.occ_zero ? sample_r : front_r;
      out_last_r <= end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;
  assign out_last       = out_last_r;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for sliding_window_maximum: directed cases, then random sample runs.
// Predicts each window maximum with its own monotonic deque and compares every result item.
// Depends on swm_pkg and the sliding_window_maximum RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int SW            = swm_pkg::SAMPLE_WIDTH;
  localparam int DEPTH         = swm_pkg::WINDOW_MAX;
  localparam int POS_SPAN      = swm_pkg::POS_MOD;
  localparam int SETTLE_CYCLES = 300;   // margin for the longest item, which examines every deque entry
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 126;
  localparam int PEND_DEPTH    = 64;    // expected results in flight, far above need

  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  // sample patterns for random runs
  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_FALLING,
    PAT_RISING,
    PAT_EXTREME
  } sample_pattern_t;

  // idle behavior of either side
  typedef enum int {
    IDLE_NONE,
    IDLE_MIXED
  } idle_mode_t;

  typedef struct packed {
    logic [SW-1:0] value;
    logic          last;
  } max_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SW-1:0]          in_sample = '0;
  logic                          in_end_of_run = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SW-1:0]          out_window_max;
  logic                          out_last;
  logic                          cfg_we = 1'b0;
  logic [swm_pkg::LEN_W-1:0]     cfg_wdata = '0;

  // deque predictor state
  logic signed [SW-1:0]          dq_value [DEPTH];
  int unsigned                   dq_pos [DEPTH];
  int unsigned                   dq_head = 0;
  int unsigned                   dq_count = 0;
  int unsigned                   stream_pos = 0;
  int unsigned                   run_seen = 0;
  logic [swm_pkg::LEN_W-1:0]     win_reg = 7'd1;

  // expected results, ring of PEND_DEPTH with free-running counters
  max_result_t                   pend_buf [PEND_DEPTH];
  int unsigned                   pend_wr = 0;
  int unsigned                   pend_rd = 0;
  int                            error_count = 0;
  idle_mode_t                    src_mode = IDLE_NONE;
  idle_mode_t                    sink_mode = IDLE_NONE;
  int                            sink_hold = 0;
  int                            items_sent = 0;

  sliding_window_maximum u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_end_of_run  (in_end_of_run),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_window_max (out_window_max),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input idle_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == IDLE_NONE || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // window length as the block applies it
  function automatic int unsigned applied_window();
    if (win_reg == 0) begin
      return 1;
    end else if (win_reg > DEPTH) begin
      return DEPTH;
    end
    return 32'(win_reg);
  endfunction

  // advance the deque by one sample, queue the result item it yields
  task automatic predict_window_max(input logic signed [SW-1:0] s, input logic eor);
    int unsigned eff;
    int unsigned age;
    int unsigned slot;
    max_result_t res;
    eff = applied_window();
    // age out the front
    while (dq_count > 0) begin
      age = (stream_pos + POS_SPAN - dq_pos[dq_head]) % POS_SPAN;
      if (age < eff) break;
      dq_head  = (dq_head + 1) % DEPTH;
      dq_count = dq_count - 1;
    end
    // pop smaller or equal entries off the back
    while (dq_count > 0) begin
      if (dq_value[(dq_head + dq_count - 1) % DEPTH] > s) break;
      dq_count = dq_count - 1;
    end
    if (dq_count < DEPTH) begin
      slot           = (dq_head + dq_count) % DEPTH;
      dq_value[slot] = s;
      dq_pos[slot]   = stream_pos;
      dq_count       = dq_count + 1;
    end
    stream_pos = (stream_pos + 1) % POS_SPAN;
    if (run_seen < DEPTH) begin
      run_seen = run_seen + 1;
    end
    if (eor || run_seen >= eff) begin
      res.value = dq_value[dq_head];
      res.last  = eor;
      pend_buf[pend_wr % PEND_DEPTH] = res;
      pend_wr = pend_wr + 1;
    end
    // end of run clears the deque
    if (eor) begin
      dq_head    = 0;
      dq_count   = 0;
      stream_pos = 0;
      run_seen   = 0;
    end
  endtask

  // send one item after a random gap, return once it is accepted
  task automatic send_sample(input logic signed [SW-1:0] s, input logic eor);
    int gap;
    gap = pick_gap(src_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_end_of_run <= eor;
    do @(posedge clk); while (!in_ready);
    predict_window_max(s, eor);
    items_sent = items_sent + 1;
  endtask

  // stop sending, wait for every expected result, then let the block go idle
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the window length while the block is idle
  task automatic set_window(input logic [swm_pkg::LEN_W-1:0] len);
    wait_results_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    win_reg    = len;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one run of samples; end_of_run on the last one if terminated
  task automatic send_run(input int len, input sample_pattern_t pat, input logic terminate);
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] s;
    logic [SW-1:0]        step;
    base = $urandom;
    step = $urandom_range(1, 1000);
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_NARROW: begin
          s = $urandom_range(0, 6) - 3;
        end
        PAT_FALLING: begin
          s = base - step * i;
        end
        PAT_RISING: begin
          s = base + step * i;
        end
        PAT_EXTREME: begin
          case ($urandom_range(0, 5))
            0: s = S_MIN;
            1: s = S_MAX;
            2: s = '0;
            3: s = -1;
            4: s = S_MIN + 1;
            default: s = S_MAX - 1;
          endcase
        end
        default: begin
          s = $urandom;
        end
      endcase
      send_sample(s, terminate && (i == len - 1));
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    max_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pend_wr == pend_rd) begin
        $error("unexpected result item: window_max %0d last %0b", out_window_max, out_last);
        error_count = error_count + 1;
      end else begin
        want    = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd = pend_rd + 1;
        if (out_window_max !== want.value) begin
          $error("window_max: expected %0d, actual %0d", $signed(want.value), out_window_max);
          error_count = error_count + 1;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          error_count = error_count + 1;
        end
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      sink_hold <= pick_gap(sink_mode);
    end
  end

  // window length 1 out of reset: every sample is its own maximum
  task automatic test_reset_window();
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b0);
  endtask

  // equal samples, short runs, zero and oversize windows, mid-run change
  task automatic test_directed_cases();
    set_window(7'd3);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(2, 1'b0);
    send_sample(7, 1'b1);
    // oversize window, run ends before it fills
    set_window(7'd127);
    send_sample(S_MIN, 1'b0);
    send_sample(3, 1'b0);
    send_sample(-1, 1'b1);
    // zero window acts as one; a run of a single sample
    set_window(7'd0);
    send_sample(-5, 1'b1);
    send_sample(9, 1'b0);
    // falling samples age out of a window of 4, then it shrinks mid-run
    set_window(7'd4);
    send_sample(10, 1'b0);
    send_sample(4, 1'b0);
    send_sample(3, 1'b0);
    send_sample(2, 1'b0);
    send_sample(1, 1'b0);
    set_window(7'd2);
    send_sample(0, 1'b0);
    send_sample(0, 1'b1);
    set_window(7'd64);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
  endtask

  // sender holds off until every result is back, then the same run goes on
  task automatic test_pause_until_drained();
    set_window(7'd8);
    src_mode  = IDLE_MIXED;
    sink_mode = IDLE_MIXED;
    send_run(30, PAT_RANDOM, 1'b0);
    wait_results_drained();
    send_run(30, PAT_FALLING, 1'b1);
  endtask

  // random runs over a spread of window lengths and idle mixes
  task automatic test_random_runs();
    logic [swm_pkg::LEN_W-1:0] windows [RANDOM_PHASES];
    int                        phase_end;
    int                        eff;
    int                        len;
    int                        r;
    windows = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd2, 7'd3, 7'd16, 7'd63, 7'd65, 7'd5, 7'd40, 7'd9};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph >= 9) begin
        windows[ph] = swm_pkg::LEN_W'($urandom_range(0, 127));
      end
      set_window(windows[ph]);
      src_mode  = (ph % 4 == 1) ? IDLE_NONE : IDLE_MIXED;
      sink_mode = (ph % 4 == 1 || ph % 4 == 3) ? IDLE_NONE : IDLE_MIXED;
      eff       = applied_window();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          len = $urandom_range(1, 3);
        end else if (r < 70) begin
          len = eff + $urandom_range(0, 12) - 2;
        end else begin
          len = $urandom_range(1, 3 * eff + 4);
        end
        if (len < 1) begin
          len = 1;
        end
        // keep the phase at its item budget
        if (len > phase_end - items_sent) begin
          len = phase_end - items_sent;
        end
        // most runs close; an open one carries over into the next run, or into the next window length
        send_run(len, sample_pattern_t'($urandom_range(0, 4)), $urandom_range(0, 9) != 0);
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_directed_cases();
    test_pause_until_drained();
    test_random_runs();
    src_mode  = IDLE_NONE;
    sink_mode = IDLE_NONE;
    wait_results_drained();
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
